// ----- design/psddt_pkg.sv -----
// ----------------------------------------------------------------------------
// psddt_pkg
// Shared constants and types for the partial S-box difference-table tracker.
// ----------------------------------------------------------------------------
package psddt_pkg;

    // Default S-box width in bits (inputs and outputs)
    localparam int IN_BITS_DEF = 8;

    // Width of each packed field slot in the stream word
    localparam int FIELD_BITS = 8;

    // Stream widths: point and image in tdata, opcode in tuser
    localparam int S_TDATA_BITS = 2 * FIELD_BITS;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 8;

    // Table entries hold half of the true count, saturating here
    localparam logic [1:0] HALF_MAX = 2'd3;
    localparam logic [1:0] HALF_ONE = 2'd1;

    // Item kinds carried on tuser
    typedef enum logic [1:0] {
        OP_ASSIGN = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

endpackage

// ----- design/psddt_ram.sv -----
// ----------------------------------------------------------------------------
// psddt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psddt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/partial_sbox_ddt_apn_tracker.sv -----
// Assign and remove walk the 2^(IN_BITS-1)-1 nonzero even-weight differences, fetching
//   and updating the table entry where the partner point is set; an assign stops at the
//   first failing entry, a remove may stop early, and an unset remove skips the walk.
// Clear zeroes the whole table, one table entry zeroed a cycle, then returns a result word.
// One word in flight; the next word can be taken in the cycle after its result word is registered.
// Reset (sync, active low) clears marks, then sweeps every table entry to zero.
// ----------------------------------------------------------------------------
// partial_sbox_ddt_apn_tracker
// Partial S-box with incremental difference-table check for APN property.
// ----------------------------------------------------------------------------
module partial_sbox_ddt_apn_tracker #(
    parameter int IN_BITS = psddt_pkg::IN_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] point, [15:8] image
    input  logic [psddt_pkg::S_TDATA_BITS-1:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [psddt_pkg::S_TUSER_BITS-1:0] i_s_axis_tuser,
    // master side
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] still_apn, [7:1] zero
    output logic [psddt_pkg::M_TDATA_BITS-1:0] o_m_axis_tdata
);

    localparam int PT_COUNT = 1 << IN_BITS;
    localparam int K_BITS   = IN_BITS - 1;
    localparam int DIFF_AW  = 2 * IN_BITS;
    localparam int DIFF_DEPTH = 1 << DIFF_AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_LOADX,
        S_PROBE,
        S_FETCH,
        S_UPDATE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state             r_state;
    psddt_pkg::t_opcode r_op;
    logic [IN_BITS-1:0] r_x;
    logic [IN_BITS-1:0] r_y;
    logic [IN_BITS-1:0] r_vx;
    logic [K_BITS-1:0]  r_k;
    logic [DIFF_AW-1:0] r_idx;
    logic [DIFF_AW-1:0] r_clr;
    logic               r_reply;
    logic               r_ok;
    logic [PT_COUNT-1:0] r_valid;
    logic               r_out_valid;
    logic               r_out_still;

    logic [IN_BITS-1:0] diff_a;
    logic [IN_BITS-1:0] other;
    logic [IN_BITS-1:0] col;
    logic               last_k;
    logic [1:0]         cur_half;
    logic [1:0]         new_half;

    logic               vram_we;
    logic [IN_BITS-1:0] vram_raddr;
    logic [IN_BITS-1:0] vram_rdata;
    logic               dram_we;
    logic [DIFF_AW-1:0] dram_waddr;
    logic [1:0]         dram_wdata;
    logic [DIFF_AW-1:0] dram_raddr;
    logic [1:0]         dram_rdata_w;

    // Even-weight difference: walk index with its parity bit appended
    assign diff_a = {r_k, ^r_k};
    assign other  = r_x ^ diff_a;
    assign col    = r_vx ^ vram_rdata;
    assign last_k = (r_k == {K_BITS{1'b1}});

    // Saturating step of the half count
    assign cur_half = dram_rdata_w;
    always_comb begin
        if (r_op == psddt_pkg::OP_ASSIGN) begin
            new_half = (cur_half == psddt_pkg::HALF_MAX) ? cur_half : cur_half + 2'd1;
        end else begin
            new_half = (cur_half == 2'd0) ? cur_half : cur_half - 2'd1;
        end
    end

    // Memory port steering
    always_comb begin
        vram_we    = (r_state == S_START) && (r_op == psddt_pkg::OP_ASSIGN);
        vram_raddr = (r_state == S_PROBE) ? other : r_x;
        dram_we    = (r_state == S_UPDATE) || (r_state == S_SWEEP);
        dram_waddr = (r_state == S_SWEEP) ? r_clr : r_idx;
        dram_wdata = (r_state == S_SWEEP) ? 2'd0 : new_half;
        dram_raddr = {diff_a, col};
    end

    // Point values, read only where the point mark is set
    psddt_ram #(
        .WIDTH (IN_BITS),
        .DEPTH (PT_COUNT)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (r_x),
        .i_wdata (r_y),
        .i_raddr (vram_raddr),
        .o_rdata (vram_rdata)
    );

    // Difference table, half counts, row = difference, column = output xor
    psddt_ram #(
        .WIDTH (2),
        .DEPTH (DIFF_DEPTH)
    ) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (dram_we),
        .i_waddr (dram_waddr),
        .i_wdata (dram_wdata),
        .i_raddr (dram_raddr),
        .o_rdata (dram_rdata_w)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(psddt_pkg::M_TDATA_BITS-1){1'b0}}, r_out_still};

    // Sequencer: state, point marks and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_clr       <= '0;
            r_reply     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b1;
        end else begin
            // Output word register: load from the done state, drop on handshake
            if ((r_state == S_DONE) && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_op    <= psddt_pkg::t_opcode'(i_s_axis_tuser);
                        r_x     <= i_s_axis_tdata[IN_BITS-1:0];
                        r_y     <= i_s_axis_tdata[psddt_pkg::FIELD_BITS +: IN_BITS];
                        r_ok    <= 1'b1;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    case (r_op)
                        psddt_pkg::OP_ASSIGN: begin
                            r_valid[r_x] <= 1'b1;
                            r_vx         <= r_y;
                            r_k          <= K_BITS'(1);
                            r_state      <= S_PROBE;
                        end
                        psddt_pkg::OP_REMOVE: begin
                            r_state <= r_valid[r_x] ? S_LOADX : S_DONE;
                        end
                        psddt_pkg::OP_CLEAR: begin
                            r_valid <= '0;
                            r_clr   <= '0;
                            r_reply <= 1'b1;
                            r_state <= S_SWEEP;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_LOADX: begin
                    r_vx    <= vram_rdata;
                    r_k     <= K_BITS'(1);
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    if (r_valid[other]) begin
                        r_state <= S_FETCH;
                    end else if (last_k) begin
                        if (r_op == psddt_pkg::OP_REMOVE) begin
                            r_valid[r_x] <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + K_BITS'(1);
                    end
                end
                S_FETCH: begin
                    r_idx   <= dram_raddr;
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (r_op == psddt_pkg::OP_ASSIGN) begin
                        if (new_half > psddt_pkg::HALF_ONE) begin
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end else if (last_k) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + K_BITS'(1);
                            r_state <= S_PROBE;
                        end
                    end else begin
                        if ((new_half == psddt_pkg::HALF_ONE) || last_k) begin
                            r_valid[r_x] <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_k     <= r_k + K_BITS'(1);
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_SWEEP: begin
                    r_clr <= r_clr + DIFF_AW'(1);
                    if (r_clr == {DIFF_AW{1'b1}}) begin
                        r_state <= r_reply ? S_DONE : S_IDLE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_still <= r_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A new output word only comes out of the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_DONE)
        else $error("output word raised outside done state");

    // The table is never written while waiting for a word
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !dram_we)
        else $error("difference table written while idle");

    // The point under a walk stays marked until the walk ends
    a_walk_point_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROBE) || (r_state == S_FETCH) || (r_state == S_UPDATE))
            |-> r_valid[r_x])
        else $error("walk runs on an unset point");

    // The difference index never hits zero during a walk
    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_k != '0))
        else $error("zero difference in walk");

endmodule

// ----- tb/psddt_apn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psddt_apn_checker
// Watches both stream channels of the S-box difference-table tracker, keeps
// its own partial S-box and half-count table, predicts the still_apn flag of
// every accepted input word and compares it with the result words in order.
// ----------------------------------------------------------------------------
module psddt_apn_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // [7:0] point, [15:8] image
    input  logic [psddt_pkg::S_TDATA_BITS-1:0] i_s_tdata,
    // [1:0] opcode
    input  logic [psddt_pkg::S_TUSER_BITS-1:0] i_s_tuser,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // [0] still_apn, [7:1] zero
    input  logic [psddt_pkg::M_TDATA_BITS-1:0] i_m_tdata,
    output int                                 o_errors,
    output int                                 o_pending
);

    localparam int PT_BITS = psddt_pkg::IN_BITS_DEF;
    localparam int NPTS    = 1 << PT_BITS;
    localparam int MT_BITS = psddt_pkg::M_TDATA_BITS;

    // Shadow of the partial S-box and the half-count difference table
    bit                 pt_set  [NPTS];
    logic [PT_BITS-1:0] pt_img  [NPTS];
    logic [1:0]         half_tab[NPTS * NPTS];

    bit apn_expected_q[$];
    bit apn_want;
    int err_cnt = 0;
    int n_results = 0;

    assign o_errors = err_cnt;

    task report_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $time, n_results, what);
        err_cnt++;
    endtask

    function automatic void clear_tables();
        foreach (pt_set[i]) pt_set[i] = 1'b0;
        foreach (half_tab[i]) half_tab[i] = 2'd0;
    endfunction

    // Applies one input word to the shadow state, returns the expected flag
    function automatic bit apply_word(logic [1:0] op, logic [PT_BITS-1:0] x,
                                      logic [PT_BITS-1:0] y);
        bit                   ok;
        logic [PT_BITS-1:0]   d;
        logic [PT_BITS-1:0]   partner;
        logic [2*PT_BITS-1:0] idx;
        ok = 1'b1;
        case (op)
            psddt_pkg::OP_ASSIGN: begin
                pt_img[x] = y;
                pt_set[x] = 1'b1;
                // walk even-weight differences, stop at first entry above 2
                for (int a = 1; a < NPTS; a++) begin
                    d = a[PT_BITS-1:0];
                    partner = x ^ d;
                    if (^d || !pt_set[partner]) continue;
                    idx = {d, pt_img[x] ^ pt_img[partner]};
                    if (half_tab[idx] != psddt_pkg::HALF_MAX)
                        half_tab[idx] = half_tab[idx] + 2'd1;
                    if (half_tab[idx] > psddt_pkg::HALF_ONE) begin
                        ok = 1'b0;
                        break;
                    end
                end
            end
            psddt_pkg::OP_REMOVE: begin
                if (pt_set[x]) begin
                    // same walk, decrementing; stops once an entry is back at 2
                    for (int a = 1; a < NPTS; a++) begin
                        d = a[PT_BITS-1:0];
                        partner = x ^ d;
                        if (^d || !pt_set[partner]) continue;
                        idx = {d, pt_img[x] ^ pt_img[partner]};
                        if (half_tab[idx] != 2'd0) half_tab[idx] = half_tab[idx] - 2'd1;
                        if (half_tab[idx] == psddt_pkg::HALF_ONE) break;
                    end
                    pt_set[x] = 1'b0;
                end
            end
            psddt_pkg::OP_CLEAR: clear_tables();
            default: ;
        endcase
        return ok;
    endfunction

    // Result words are matched before the same-edge input word is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tables();
            apn_expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (apn_expected_q.size() == 0) begin
                    report_mismatch("result word with no input word outstanding");
                end else begin
                    apn_want = apn_expected_q.pop_front();
                    if (i_m_tdata[0] !== apn_want)
                        report_mismatch($sformatf("still_apn %b, expected %b",
                                                  i_m_tdata[0], apn_want));
                    if (i_m_tdata[MT_BITS-1:1] !== '0)
                        report_mismatch($sformatf("pad bits %h not zero",
                                                  i_m_tdata[MT_BITS-1:1]));
                end
                n_results++;
            end
            if (i_s_tvalid && i_s_tready)
                apn_expected_q.push_back(apply_word(
                    i_s_tuser,
                    i_s_tdata[PT_BITS-1:0],
                    i_s_tdata[psddt_pkg::FIELD_BITS +: PT_BITS]));
            o_pending <= apn_expected_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the partial S-box difference-table tracker: a directed run
// through saturation, underflow, unset removes, unused opcodes and clears,
// then random assign/remove sequences over a tracked set of live points,
// with random idling on both sides, two long receiver hold-offs and a drain.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         N_RANDOM    = 1234;
    localparam int         QUIET_LIMIT = 300000;
    localparam int         TAIL_CYCLES = 500;
    localparam int         HOLD_CYCLES = 3000;

    logic                               i_clk;
    logic                               i_rst_n  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [psddt_pkg::S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [psddt_pkg::S_TUSER_BITS-1:0] s_tuser  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [psddt_pkg::M_TDATA_BITS-1:0] m_tdata;

    int err_cnt;
    int exp_left;
    int n_sent = 0;
    int quiet  = 0;

    partial_sbox_ddt_apn_tracker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    psddt_apn_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (err_cnt),
        .o_pending  (exp_left)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run after a long stretch with no word accepted
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Offers one word after a random gap; every fourth block of 64 is gap-free
    task automatic send_word(input logic [1:0] op, input logic [7:0] pt,
                             input logic [7:0] img);
        int gap;
        gap = ((n_sent / 64) % 4 == 3) ? 0 : int'($urandom_range(0, 9));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tuser  <= op;
        s_tdata  <= {img, pt};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
    endtask

    // Stops offering until every outstanding result word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (exp_left != 0);
    endtask

    // Receiver: random stalls, gap-free stretches and two long hold-offs
    initial begin
        int gap;
        int n_got;
        n_got = 0;
        forever begin
            if (n_got == 100 || n_got == 700) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = ((n_got / 50) % 4 == 1) ? 0 : int'($urandom_range(0, 9));
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            n_got++;
        end
    end

    // Stimulus and verdict
    initial begin
        logic [7:0] live_q[$];
        logic [7:0] pt;
        int         roll;
        int         rm_pct;
        int         j;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // saturate entry (3,0): pair 1/2 pushed three times
        send_word(psddt_pkg::OP_ASSIGN, 8'h01, 8'h00);
        send_word(psddt_pkg::OP_ASSIGN, 8'h02, 8'h00);
        send_word(psddt_pkg::OP_ASSIGN, 8'h02, 8'h00);
        send_word(psddt_pkg::OP_ASSIGN, 8'h02, 8'h00);
        // point 0 fails on its first partner, so its partner 5 is never counted
        send_word(psddt_pkg::OP_ASSIGN, 8'h03, 8'h00);
        send_word(psddt_pkg::OP_ASSIGN, 8'h05, 8'h00);
        send_word(psddt_pkg::OP_ASSIGN, 8'h00, 8'h00);
        // remove walks past the saturated entry into a zero one
        send_word(psddt_pkg::OP_REMOVE, 8'h00, 8'hff);
        send_word(psddt_pkg::OP_REMOVE, 8'h00, 8'h5a);
        send_word(OP_UNUSED, 8'hff, 8'hff);
        send_word(psddt_pkg::OP_ASSIGN, 8'hff, 8'hff);
        send_word(psddt_pkg::OP_ASSIGN, 8'hfc, 8'hff);
        send_word(psddt_pkg::OP_ASSIGN, 8'hfa, 8'h00);
        send_word(psddt_pkg::OP_REMOVE, 8'hff, 8'h00);
        send_word(psddt_pkg::OP_CLEAR, 8'haa, 8'h55);
        send_word(psddt_pkg::OP_ASSIGN, 8'h00, 8'hff);
        send_word(psddt_pkg::OP_REMOVE, 8'hfc, 8'h00);
        send_word(OP_UNUSED, 8'h00, 8'h00);
        wait_drained();

        // random assign/remove sequences over the live point set
        for (int k = 0; k < N_RANDOM; k++) begin
            roll   = $urandom_range(0, 99);
            rm_pct = (live_q.size() > 24) ? 60 : 30;
            if (k == 600) wait_drained();
            if (k == 400 || k == 800) begin
                send_word(psddt_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
                live_q.delete();
            end else if (roll < 2) begin
                send_word(OP_UNUSED, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end else if (roll < 2 + rm_pct) begin
                if (live_q.size() > 0 && $urandom_range(0, 9) != 0) begin
                    j  = $urandom_range(0, live_q.size() - 1);
                    pt = live_q[j];
                    live_q.delete(j);
                end else begin
                    pt = 8'($urandom_range(0, 255));
                end
                send_word(psddt_pkg::OP_REMOVE, pt, 8'($urandom_range(0, 255)));
            end else begin
                // occasionally overwrite a live point without removing it
                if (live_q.size() > 0 && $urandom_range(0, 5) == 0) begin
                    pt = live_q[$urandom_range(0, live_q.size() - 1)];
                end else begin
                    pt = 8'($urandom_range(0, 255));
                    live_q.push_back(pt);
                end
                send_word(psddt_pkg::OP_ASSIGN, pt, 8'($urandom_range(0, 255)));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && exp_left == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/psddt_pkg.sv
design/psddt_ram.sv
design/partial_sbox_ddt_apn_tracker.sv
tb/psddt_apn_checker.sv
tb/tb.sv
